### rtl/core/adts_pkg.sv
// Shared types and constants for the ADTS frame splitter.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package adts_pkg;

  localparam int HDR_LEN   = 7;
  localparam int HDR_IDX_W = 3;
  localparam int LEN_W     = 13;
  localparam int FNUM_W    = 16;
  localparam int JOB_DEPTH = 8;
  localparam int JOB_PTR_W = 3;
  localparam int JOB_CNT_W = 4;

  localparam logic [7:0]           SYNC_BYTE    = 8'hFF;
  localparam logic [3:0]           SYNC_NIBBLE  = 4'hF;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_LEN - 1);
  localparam logic [LEN_W-1:0]     HDR_LEN_L    = LEN_W'(HDR_LEN);

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_HEAD = 3'b010,
    PH_BODY = 3'b100
  } adts_phase_t;

  // One queued job: a whole header burst or a single payload byte.
  typedef struct packed {
    logic                         is_hdr;
    logic [HDR_LEN-1:0][7:0]      bytes;      // body jobs use bytes[0]
    logic                         frame_end;  // job closes the frame
    logic [LEN_W-1:0]             frame_length;
    logic [1:0]                   profile;
    logic [3:0]                   rate_index;
    logic [FNUM_W-1:0]            frame_number;
  } adts_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } adts_q_stat_t;

endpackage

### rtl/core/adts_front.sv
// Front end: byte intake, sync hunt, header capture and job build.
// Depends on adts_pkg; feeds adts_job_fifo.
`timescale 1ns / 1ps

module adts_front import adts_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic [7:0]   in_byte,
  output logic         in_ready,
  input  adts_q_stat_t q_stat,
  output logic         push,
  output adts_job_t    push_job
);

  adts_phase_t               phase_r, phase_nxt;
  logic                      prev_ff_r, prev_ff_nxt;
  logic [HDR_IDX_W-1:0]      hcount_r, hcount_nxt;
  logic [LEN_W-1:0]          left_r, left_nxt;
  logic [FNUM_W-1:0]         fcount_r, fcount_nxt;
  logic [HDR_LEN-1:0][7:0]   store_r;

  logic             accept;
  logic             sync_hit;
  logic             head_we;
  logic [LEN_W-1:0] cur_len;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign cur_len  = {store_r[3][1:0], store_r[4], store_r[5][7:5]};

  always_comb begin
    phase_nxt   = phase_r;
    prev_ff_nxt = prev_ff_r;
    hcount_nxt  = hcount_r;
    left_nxt    = left_r;
    fcount_nxt  = fcount_r;
    sync_hit    = 1'b0;
    head_we     = 1'b0;
    push        = 1'b0;

    push_job              = '0;
    push_job.frame_length = cur_len;
    push_job.profile      = store_r[2][7:6];
    push_job.rate_index   = store_r[2][5:2];
    push_job.frame_number = fcount_r;

    if (accept) begin
      unique case (phase_r)
        PH_HEAD: begin
          head_we = 1'b1;
          if (hcount_r == HDR_LAST_IDX) begin
            // header bytes 3..5 are already held, length is final here
            if (cur_len < HDR_LEN_L) begin
              phase_nxt   = PH_HUNT;
              hcount_nxt  = '0;
              prev_ff_nxt = (in_byte == SYNC_BYTE);
            end else begin
              push            = 1'b1;
              push_job.is_hdr = 1'b1;
              for (int k = 0; k < HDR_LEN - 1; k++) begin
                push_job.bytes[k] = store_r[k];
              end
              push_job.bytes[HDR_LEN-1] = in_byte;
              push_job.frame_end        = (cur_len == HDR_LEN_L);
              if (cur_len == HDR_LEN_L) begin
                fcount_nxt  = fcount_r + 1'b1;
                phase_nxt   = PH_HUNT;
                prev_ff_nxt = 1'b0;
                hcount_nxt  = '0;
                left_nxt    = '0;
              end else begin
                left_nxt  = cur_len - HDR_LEN_L;
                phase_nxt = PH_BODY;
              end
            end
          end else begin
            hcount_nxt = hcount_r + 1'b1;
          end
        end
        PH_BODY: begin
          push               = 1'b1;
          push_job.bytes[0]  = in_byte;
          push_job.frame_end = (left_r <= LEN_W'(1));
          if (left_r <= LEN_W'(1)) begin
            fcount_nxt  = fcount_r + 1'b1;
            phase_nxt   = PH_HUNT;
            prev_ff_nxt = 1'b0;
            hcount_nxt  = '0;
            left_nxt    = '0;
          end else begin
            left_nxt = left_r - 1'b1;
          end
        end
        default: begin
          // hunting; an illegal phase code behaves the same
          if (prev_ff_r && (in_byte[7:4] == SYNC_NIBBLE)) begin
            sync_hit    = 1'b1;
            hcount_nxt  = HDR_IDX_W'(2);
            prev_ff_nxt = 1'b0;
            phase_nxt   = PH_HEAD;
          end else begin
            phase_nxt   = PH_HUNT;
            prev_ff_nxt = (in_byte == SYNC_BYTE);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      prev_ff_r <= 1'b0;
      hcount_r  <= '0;
      left_r    <= '0;
      fcount_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      prev_ff_r <= prev_ff_nxt;
      hcount_r  <= hcount_nxt;
      left_r    <= left_nxt;
      fcount_r  <= fcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sync_hit) begin
      store_r[0] <= SYNC_BYTE;
      store_r[1] <= in_byte;
    end
    if (head_we) begin
      store_r[hcount_r] <= in_byte;
    end
  end

`ifndef SYNTH
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEAD) |-> (hcount_r >= HDR_IDX_W'(2) && hcount_r <= HDR_LAST_IDX))
    else $error("header count out of range while collecting header");
  a_sync_enters_head: assert property (@(posedge clk) disable iff (!rst_n)
    sync_hit |=> (phase_r == PH_HEAD && !prev_ff_r))
    else $error("sync pair did not start header capture");
`endif

endmodule

### rtl/core/adts_job_fifo.sv
// Short job queue between front end and output sequencer.
// Depends on adts_pkg (adts_job_t, depth constants).
`timescale 1ns / 1ps

module adts_job_fifo import adts_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  adts_job_t    push_job,
  input  logic         pop,
  output adts_job_t    head_job,
  output adts_q_stat_t q_stat
);

  adts_job_t               slot_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [JOB_CNT_W-1:0]    count_r, count_nxt;

  assign q_stat.full  = (count_r == JOB_CNT_W'(JOB_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_job     = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop))
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("job queue underflow");
`endif

endmodule

### rtl/core/adts_back.sv
// Output sequencer: expands queued jobs into output words.
// Depends on adts_pkg; pulls jobs from adts_job_fifo.
`timescale 1ns / 1ps

module adts_back import adts_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  adts_job_t    head_job,
  input  adts_q_stat_t q_stat,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   frame_byte,
  output logic         frame_start,
  output logic         frame_end,
  output logic         run_last,
  output logic [LEN_W-1:0]  frame_length,
  output logic [1:0]        profile,
  output logic [3:0]        rate_index,
  output logic [FNUM_W-1:0] frame_number
);

  adts_job_t            job_r;
  logic                 active_r;
  logic [HDR_IDX_W-1:0] idx_r;

  logic fire;
  logic job_done;
  logic take;

  assign out_valid = active_r;
  assign fire      = active_r && out_ready;
  assign job_done  = !job_r.is_hdr || (idx_r == HDR_LAST_IDX);
  assign take      = !active_r || (fire && job_done);
  assign pop       = take && !q_stat.empty;

  assign frame_byte   = job_r.bytes[idx_r];
  assign frame_start  = job_r.is_hdr && (idx_r == '0);
  assign run_last     = job_done;
  assign frame_end    = job_r.frame_end && job_done;
  assign frame_length = job_r.frame_length;
  assign profile      = job_r.profile;
  assign rate_index   = job_r.rate_index;
  assign frame_number = job_r.frame_number;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (take) begin
        active_r <= !q_stat.empty;
        idx_r    <= '0;
      end else if (fire) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head_job;
    end
  end

`ifndef SYNTH
  a_body_single: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && !job_r.is_hdr) |-> (idx_r == '0))
    else $error("payload job advanced past its only word");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (idx_r <= HDR_LAST_IDX))
    else $error("header word index out of range");
`endif

endmodule

### rtl/core/adts_frame_splitter.sv
// ADTS frame splitter top: one stream byte in per cycle, frame bytes out.
// Jobs pass the queue, then job_r; output words leave only while out_tready is high.
// Throughput: 1 input byte per cycle; 1 output word per cycle, a header leaves as 7.
// An 8-deep job queue absorbs the header burst; input stalls only when it is full.
// Reset: synchronous active-low rst_n clears the control state.
`timescale 1ns / 1ps

module adts_frame_splitter import adts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] frame_byte, [20:8] frame_length,
                                  // [22:21] profile, [26:23] rate_index,
                                  // [42:27] frame_number, [47:43] zero
  output logic        out_tlast,  // frame_end
  output logic [1:0]  out_tuser   // [0] frame_start, [1] run_last
);

  adts_q_stat_t      q_stat;
  adts_job_t         push_job, head_job;
  logic              push, pop;
  logic [7:0]        frame_byte;
  logic              frame_start, frame_end, run_last;
  logic [LEN_W-1:0]  frame_length;
  logic [1:0]        profile;
  logic [3:0]        rate_index;
  logic [FNUM_W-1:0] frame_number;

  adts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_ready (in_tready),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  adts_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  adts_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_job     (head_job),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .frame_byte   (frame_byte),
    .frame_start  (frame_start),
    .frame_end    (frame_end),
    .run_last     (run_last),
    .frame_length (frame_length),
    .profile      (profile),
    .rate_index   (rate_index),
    .frame_number (frame_number)
  );

  assign out_tdata = {5'b0, frame_number, rate_index, profile, frame_length, frame_byte};
  assign out_tlast = frame_end;
  assign out_tuser = {run_last, frame_start};

endmodule
